// File: rtl/core/thss_pkg.sv
// ----------------------------------------------------------------------------
// thss_pkg
// Shared types and constants of the terrain height sculpt and sample block.
// ----------------------------------------------------------------------------
package thss_pkg;

	// count of vertices along one axis as held in the registers
	localparam int CNT_W   = 9;
	// flat vertex index built from two counts
	localparam int IDX_W   = 2 * CNT_W;
	// clamped query coordinate: spacing times a count
	localparam int LIM_W   = 40;
	// signed vertex coordinate inside an edit sweep
	localparam int COORD_W = 48;
	// shared divider: dividend, divisor and quotient widths
	localparam int DVD_W   = 64;
	localparam int DIVR_W  = 40;
	localparam int QUO_W   = 32;

	// item kinds
	localparam logic [2:0] KIND_QUERY = 3'd0;
	localparam logic [2:0] KIND_RAISE = 3'd1;
	localparam logic [2:0] KIND_LOWER = 3'd2;
	localparam logic [2:0] KIND_WRITE = 3'd3;
	localparam logic [2:0] KIND_CLEAR = 3'd4;

	// configuration register indexes
	localparam logic [2:0] CFG_SPACING  = 3'd0;
	localparam logic [2:0] CFG_RADIUS   = 3'd1;
	localparam logic [2:0] CFG_STRENGTH = 3'd2;
	localparam logic [2:0] CFG_COLS     = 3'd3;
	localparam logic [2:0] CFG_ROWS     = 3'd4;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_z;
		logic [15:0]        vertex_index;
		logic signed [31:0] height_value;
	} thss_item_t;

	typedef struct packed {
		logic signed [31:0] result_height;
		logic [16:0]        vertices_changed;
		logic [7:0]         cell_col;
		logic [7:0]         cell_row;
		logic               upper_triangle;
	} thss_result_t;

endpackage

// File: rtl/core/terrain_height_sculpt_and_sample.sv
// ----------------------------------------------------------------------------
// terrain_height_sculpt_and_sample
// Heightmap store with brush raise/lower, vertex write, clear and a
// triangle-plane height query.
// ----------------------------------------------------------------------------
// Usage:
// - item channel (item_valid/item_stall/item) takes one command word; the
//   block handles one word at a time and holds item_stall high while busy.
// - result channel (result_valid/result_stall/result) returns exactly one
//   word per command from an output register; the next command is taken
//   while that word still waits, and a stalled receiver only holds the
//   block once the following result is also ready.
// - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes a register
//   on each clock edge where cfg_valid is high; cfg_ready is always high.
// - a query runs three divisions on the shared divider; clear writes all
//   MAX_COLS*MAX_ROWS store entries, one per cycle; an edit visits every
//   row and, in rows inside the brush box, every column, and each vertex
//   inside the brush takes a square root and a division.
// - reset: a clearing pass zeroes all MAX_COLS*MAX_ROWS entries, one per
//   cycle, before the first command is taken.
// ----------------------------------------------------------------------------
module terrain_height_sculpt_and_sample #(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  thss_pkg::thss_item_t   item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output thss_pkg::thss_result_t result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [31:0]            cfg_data
);
	import thss_pkg::*;

	localparam int DEPTH  = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DONE,
		S_Q_LIM, S_Q_CLAMP, S_Q_DIVX, S_Q_DIVZ, S_Q_FRAC, S_Q_READ,
		S_Q_MAC, S_Q_SUM, S_Q_HDIV,
		S_E_INIT, S_E_ROW, S_E_ROWSQ, S_E_COL, S_E_DX, S_E_D2,
		S_E_SQRT, S_E_MUL, S_E_DIV
	} state_t;

	state_t state_q;

	// configuration registers
	logic [30:0]      spacing_q, radius_q, strength_q;
	logic [CNT_W-1:0] cols_q, rows_q;
	logic [30:0]      s_eff, rad_eff;
	logic [CNT_W-1:0] cols_eff, rows_eff;
	logic [IDX_W-1:0] cells_w;

	// command and result
	thss_item_t   item_q;
	thss_result_t res_q;
	logic         rvalid_q;
	thss_result_t result_q;
	logic         out_free;

	// clearing pass
	logic [ADDR_W-1:0] clr_q;
	logic              clr_item_q;

	// query datapath
	logic [LIM_W-1:0]        xmax_q, zmax_q, x_q, z_q;
	logic [LIM_W-1:0]        xmax_w, zmax_w, xcol_w, zrow_w;
	logic [CNT_W-1:0]        col_q, row_q;
	logic [31:0]             fx_q, fz_q;
	logic [IDX_W-1:0]        base_q, base_w;
	logic [2:0]              rd_q;
	logic [31:0]             hq_q [4];
	logic                    upper_q;
	logic [1:0]              mac_q;
	logic [31:0]             w_sel;
	logic signed [31:0]      h_sel;
	logic signed [64:0]      mac_prod;
	logic signed [63:0]      prod_q;
	logic signed [65:0]      acc_q, sbias_w, shalf_w;
	logic [DVD_W-1:0]        nq_q;
	logic signed [COORD_W-1:0] px_w, pz_w;

	// edit datapath
	logic signed [COORD_W-1:0] zacc_q, xacc_q, dz_w, dx_w, rad_w;
	logic [61:0]      r2_w, r2_q, dz2_q, dx2_q, sq_w, eprod_w, eprod_q;
	logic [30:0]      adz_q, adx_q, sq_in, dist_q;
	logic [62:0]      d2_w;
	logic [DIVR_W-1:0] den_q, add25_q;
	logic [16:0]      cnt_q;
	logic [31:0]      hcur_q;
	logic [32:0]      hsum_w;
	logic [31:0]      hnew_w;
	logic             out_z, out_x, adv_col, adv_row, last_col, last_row;

	// shared units
	logic              div_start_q, div_done, div_ok;
	logic [DVD_W-1:0]  div_dvd;
	logic [DIVR_W-1:0] div_dvs;
	logic [QUO_W-1:0]  div_q;
	logic              sq_start_q, sq_done, sq_ok;
	logic [31:0]       sq_root;

	// store ports
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [31:0]       mem_wdata, mem_rdata;

	// effective register values
	always_comb begin
		s_eff   = (spacing_q == '0) ? 31'd1 : spacing_q;
		rad_eff = (radius_q == '0) ? 31'd1 : radius_q;
		if (cols_q < CNT_W'(2)) begin
			cols_eff = CNT_W'(2);
		end else if (32'(cols_q) > MAX_COLS) begin
			cols_eff = CNT_W'(MAX_COLS);
		end else begin
			cols_eff = cols_q;
		end
		if (rows_q < CNT_W'(2)) begin
			rows_eff = CNT_W'(2);
		end else if (32'(rows_q) > MAX_ROWS) begin
			rows_eff = CNT_W'(MAX_ROWS);
		end else begin
			rows_eff = rows_q;
		end
	end

	assign cells_w = cols_eff * rows_eff;

	// small multipliers of the query setup
	assign xmax_w = s_eff * (cols_eff - 1'b1);
	assign zmax_w = s_eff * (rows_eff - 1'b1);
	assign xcol_w = col_q * s_eff;
	assign zrow_w = row_q * s_eff;
	assign base_w = row_q * cols_eff;

	assign px_w = COORD_W'(item_q.pos_x);
	assign pz_w = COORD_W'(item_q.pos_z);

	// barycentric weight and corner height of the current product
	always_comb begin
		w_sel = '0;
		h_sel = '0;
		unique case (mac_q)
			2'd0: begin
				w_sel = upper_q ? (32'(s_eff) - fz_q) : (32'(s_eff) - fx_q);
				h_sel = $signed(hq_q[0]);
			end
			2'd1: begin
				w_sel = upper_q ? (fz_q - fx_q) : (fx_q - fz_q);
				h_sel = upper_q ? $signed(hq_q[2]) : $signed(hq_q[1]);
			end
			2'd2: begin
				w_sel = upper_q ? fx_q : fz_q;
				h_sel = $signed(hq_q[3]);
			end
			default: begin
				w_sel = '0;
				h_sel = '0;
			end
		endcase
	end

	assign mac_prod = $signed({1'b0, w_sel}) * h_sel;
	assign sbias_w  = $signed({4'b0, s_eff, 31'b0});
	assign shalf_w  = $signed({36'b0, s_eff[30:1]});

	// edit geometry
	assign rad_w  = $signed(COORD_W'(rad_eff));
	assign dz_w   = zacc_q - pz_w;
	assign dx_w   = xacc_q - px_w;
	assign out_z  = (dz_w > rad_w) || (dz_w < -rad_w);
	assign out_x  = (dx_w > rad_w) || (dx_w < -rad_w);
	assign r2_w   = rad_eff * rad_eff;
	assign sq_in  = (state_q == S_E_ROWSQ) ? adz_q : adx_q;
	assign sq_w   = sq_in * sq_in;
	assign d2_w   = {1'b0, dx2_q} + {1'b0, dz2_q};
	assign eprod_w = strength_q * (rad_eff - dist_q);

	// new height, saturated
	always_comb begin
		if (item_q.kind == KIND_LOWER) begin
			hsum_w = {hcur_q[31], hcur_q} - {1'b0, div_q};
		end else begin
			hsum_w = {hcur_q[31], hcur_q} + {1'b0, div_q};
		end
		if (hsum_w[32] != hsum_w[31]) begin
			hnew_w = hsum_w[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			hnew_w = hsum_w[31:0];
		end
	end

	assign div_ok = div_done && !div_start_q;
	assign sq_ok  = sq_done && !sq_start_q;

	// sweep stepping
	assign last_col = col_q == cols_eff - 1'b1;
	assign last_row = row_q == rows_eff - 1'b1;
	assign adv_col  = ((state_q == S_E_COL) && out_x) ||
		((state_q == S_E_D2) && (d2_w > {1'b0, r2_q})) ||
		((state_q == S_E_DIV) && div_ok);
	assign adv_row  = ((state_q == S_E_ROW) && out_z) || (adv_col && last_col);

	// divider operands
	always_comb begin
		unique case (state_q)
			S_Q_DIVX: begin
				div_dvd = DVD_W'(x_q);
				div_dvs = DIVR_W'(s_eff);
			end
			S_Q_DIVZ: begin
				div_dvd = DVD_W'(z_q);
				div_dvs = DIVR_W'(s_eff);
			end
			S_Q_HDIV: begin
				div_dvd = nq_q;
				div_dvs = DIVR_W'(s_eff);
			end
			default: begin
				div_dvd = DVD_W'(eprod_q) + DVD_W'(add25_q);
				div_dvs = den_q;
			end
		endcase
	end

	// store port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		priority case (1'b1)
			state_q == S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			(state_q == S_IDLE) && item_valid && (item.kind == KIND_WRITE): begin
				mem_we    = IDX_W'(item.vertex_index) < cells_w;
				mem_waddr = ADDR_W'(item.vertex_index);
				mem_wdata = item.height_value;
			end
			(state_q == S_E_DIV) && div_ok: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(base_q + IDX_W'(col_q));
				mem_wdata = hnew_w;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
		if ((state_q == S_Q_READ) && (rd_q != 3'd4)) begin
			mem_re = 1'b1;
			unique case (rd_q[1:0])
				2'd0: mem_raddr = ADDR_W'(base_q);
				2'd1: mem_raddr = ADDR_W'(base_q + 1'b1);
				2'd2: mem_raddr = ADDR_W'(base_q + IDX_W'(cols_eff));
				default: mem_raddr = ADDR_W'(base_q + IDX_W'(cols_eff) + 1'b1);
			endcase
		end else if ((state_q == S_E_D2) && !(d2_w > {1'b0, r2_q})) begin
			mem_re    = 1'b1;
			mem_raddr = ADDR_W'(base_q + IDX_W'(col_q));
		end
	end

	assign out_free = !rvalid_q || !result_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q  <= 31'd65536;
			radius_q   <= 31'd327680;
			strength_q <= 31'd65536;
			cols_q     <= CNT_W'(256);
			rows_q     <= CNT_W'(256);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SPACING:  spacing_q  <= cfg_data[30:0];
				CFG_RADIUS:   radius_q   <= cfg_data[30:0];
				CFG_STRENGTH: strength_q <= cfg_data[30:0];
				CFG_COLS:     cols_q     <= cfg_data[CNT_W-1:0];
				CFG_ROWS:     rows_q     <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			clr_item_q  <= 1'b0;
			rvalid_q    <= 1'b0;
			div_start_q <= 1'b0;
			sq_start_q  <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			sq_start_q  <= 1'b0;
			if (rvalid_q && !result_stall) begin
				rvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= clr_item_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						item_q <= item;
						res_q  <= '0;
						unique case (item.kind)
							KIND_QUERY: state_q <= S_Q_LIM;
							KIND_RAISE, KIND_LOWER: state_q <= S_E_INIT;
							KIND_CLEAR: begin
								clr_q      <= '0;
								clr_item_q <= 1'b1;
								state_q    <= S_CLEAR;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_DONE: begin
					if (out_free) begin
						result_q   <= res_q;
						rvalid_q   <= 1'b1;
						clr_item_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				// query: clamp, cell lookup, corner reads, plane sum and division
				S_Q_LIM: begin
					xmax_q  <= xmax_w;
					zmax_q  <= zmax_w;
					state_q <= S_Q_CLAMP;
				end
				S_Q_CLAMP: begin
					if (px_w < 0) begin
						x_q <= '0;
					end else if (px_w > $signed(COORD_W'(xmax_q))) begin
						x_q <= xmax_q;
					end else begin
						x_q <= LIM_W'(px_w);
					end
					if (pz_w < 0) begin
						z_q <= '0;
					end else if (pz_w > $signed(COORD_W'(zmax_q))) begin
						z_q <= zmax_q;
					end else begin
						z_q <= LIM_W'(pz_w);
					end
					div_start_q <= 1'b1;
					state_q     <= S_Q_DIVX;
				end
				S_Q_DIVX: begin
					if (div_ok) begin
						col_q <= (div_q > QUO_W'(cols_eff - CNT_W'(2))) ?
							cols_eff - CNT_W'(2) : div_q[CNT_W-1:0];
						div_start_q <= 1'b1;
						state_q     <= S_Q_DIVZ;
					end
				end
				S_Q_DIVZ: begin
					if (div_ok) begin
						row_q <= (div_q > QUO_W'(rows_eff - CNT_W'(2))) ?
							rows_eff - CNT_W'(2) : div_q[CNT_W-1:0];
						state_q <= S_Q_FRAC;
					end
				end
				S_Q_FRAC: begin
					fx_q    <= 32'(x_q - xcol_w);
					fz_q    <= 32'(z_q - zrow_w);
					base_q  <= base_w + IDX_W'(col_q);
					rd_q    <= '0;
					state_q <= S_Q_READ;
				end
				S_Q_READ: begin
					if (rd_q != 3'd0) begin
						hq_q[2'(rd_q - 3'd1)] <= mem_rdata;
					end
					rd_q <= rd_q + 1'b1;
					if (rd_q == 3'd4) begin
						upper_q <= fz_q > fx_q;
						mac_q   <= '0;
						acc_q   <= '0;
						state_q <= S_Q_MAC;
					end
				end
				S_Q_MAC: begin
					prod_q <= mac_prod[63:0];
					if (mac_q != 2'd0) begin
						acc_q <= acc_q + 66'(prod_q);
					end
					mac_q <= mac_q + 1'b1;
					if (mac_q == 2'd3) begin
						state_q <= S_Q_SUM;
					end
				end
				S_Q_SUM: begin
					nq_q        <= DVD_W'(acc_q + shalf_w + sbias_w);
					div_start_q <= 1'b1;
					state_q     <= S_Q_HDIV;
				end
				S_Q_HDIV: begin
					if (div_ok) begin
						res_q.result_height  <= div_q ^ 32'h8000_0000;
						res_q.cell_col       <= col_q[7:0];
						res_q.cell_row       <= row_q[7:0];
						res_q.upper_triangle <= upper_q;
						state_q              <= S_DONE;
					end
				end
				// edit: sweep the grid row by row, read-modify-write the vertices inside
				S_E_INIT: begin
					r2_q    <= r2_w;
					den_q   <= (DIVR_W'(rad_eff) << 5) + (DIVR_W'(rad_eff) << 4) +
						(DIVR_W'(rad_eff) << 1);
					add25_q <= (DIVR_W'(rad_eff) << 4) + (DIVR_W'(rad_eff) << 3) +
						DIVR_W'(rad_eff);
					row_q   <= '0;
					zacc_q  <= '0;
					base_q  <= '0;
					cnt_q   <= '0;
					state_q <= S_E_ROW;
				end
				S_E_ROW: begin
					adz_q   <= dz_w[COORD_W-1] ? 31'(-dz_w) : 31'(dz_w);
					state_q <= S_E_ROWSQ;
				end
				S_E_ROWSQ: begin
					dz2_q   <= sq_w;
					col_q   <= '0;
					xacc_q  <= '0;
					state_q <= S_E_COL;
				end
				S_E_COL: begin
					adx_q   <= dx_w[COORD_W-1] ? 31'(-dx_w) : 31'(dx_w);
					state_q <= S_E_DX;
				end
				S_E_DX: begin
					dx2_q   <= sq_w;
					state_q <= S_E_D2;
				end
				// only a vertex inside the brush is counted and updated
				S_E_D2: begin
					if (!(d2_w > {1'b0, r2_q})) begin
						cnt_q      <= cnt_q + 1'b1;
						sq_start_q <= 1'b1;
						state_q    <= S_E_SQRT;
					end
				end
				S_E_SQRT: begin
					if (sq_ok) begin
						dist_q  <= (sq_root > 32'(rad_eff)) ? rad_eff : sq_root[30:0];
						hcur_q  <= mem_rdata;
						state_q <= S_E_MUL;
					end
				end
				S_E_MUL: begin
					eprod_q     <= eprod_w;
					div_start_q <= 1'b1;
					state_q     <= S_E_DIV;
				end
				S_E_DIV: begin
				end
				default: state_q <= S_IDLE;
			endcase
			// step to the next vertex or row of the sweep
			if (adv_row) begin
				if (last_row) begin
					res_q.vertices_changed <= cnt_q;
					state_q                <= S_DONE;
				end else begin
					row_q   <= row_q + 1'b1;
					zacc_q  <= zacc_q + COORD_W'(s_eff);
					base_q  <= base_q + IDX_W'(cols_eff);
					state_q <= S_E_ROW;
				end
			end else if (adv_col) begin
				col_q   <= col_q + 1'b1;
				xacc_q  <= xacc_q + COORD_W'(s_eff);
				state_q <= S_E_COL;
			end
		end
	end

	// multi-cycle arithmetic units
	thss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_q)
	);

	thss_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start_q),
		.radicand (64'(d2_w)),
		.done     (sq_done),
		.root     (sq_root)
	);

	thss_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// ports
	assign item_stall   = state_q != S_IDLE;
	assign result_valid = rvalid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

	// an accepted word always leaves the idle state
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> state_q != S_IDLE)
		else $error("accepted word did not start work");

	// a new result word comes only from the completion state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == S_DONE)
		else $error("result word raised outside completion");

	// stores other than the clearing pass stay inside the active grid
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && state_q != S_CLEAR |-> IDX_W'(mem_waddr) < cells_w)
		else $error("store write outside the active grid");

endmodule

// File: rtl/core/thss_store.sv
// ----------------------------------------------------------------------------
// thss_store
// Vertex height memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module thss_store #(
	parameter int DEPTH  = 65536,
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [31:0]       wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [31:0]       rdata
);

	logic [31:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/thss_div.sv
// ----------------------------------------------------------------------------
// thss_div
// Restoring divider, one quotient bit per cycle. The upper half of the
// dividend must be below the divisor so that the quotient fits its width.
// ----------------------------------------------------------------------------
module thss_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [thss_pkg::DVD_W-1:0]  dividend,
	input  logic [thss_pkg::DIVR_W-1:0] divisor,
	output logic                       done,
	output logic [thss_pkg::QUO_W-1:0]  quotient
);
	import thss_pkg::*;

	localparam int CNT_BITS = $clog2(QUO_W);

	logic [DIVR_W-1:0]   rem_q;
	logic [DIVR_W-1:0]   dvs_q;
	logic [QUO_W-1:0]    low_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [DIVR_W:0]     trial;
	logic [DIVR_W:0]     diff;
	logic                ge;

	// one trial subtraction
	assign trial = {rem_q, low_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			rem_q  <= DIVR_W'(dividend[DVD_W-1:QUO_W]);
			low_q  <= dividend[QUO_W-1:0];
			dvs_q  <= divisor;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
			low_q <= {low_q[QUO_W-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_BITS'(QUO_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done     = done_q;
	assign quotient = low_q;

endmodule

// File: rtl/core/thss_sqrt.sv
// ----------------------------------------------------------------------------
// thss_sqrt
// Integer square root, floor, one root bit per cycle.
// ----------------------------------------------------------------------------
module thss_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] v_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [35:0] r4;
	logic [35:0] trial;
	logic [35:0] diff;
	logic        ge;

	// bring down two radicand bits and try root*4+1
	assign r4    = {rem_q, v_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = r4 >= trial;
	assign diff  = r4 - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			v_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			v_q    <= {v_q[61:0], 2'b00};
			rem_q  <= ge ? diff[33:0] : r4[33:0];
			root_q <= {root_q[30:0], ge};
			cnt_q  <= cnt_q + 1'b1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: sim/tb_terrain_height_sculpt_and_sample.sv
// ----------------------------------------------------------------------------
// tb_terrain_height_sculpt_and_sample
// Self-checking bench for the terrain height store. It keeps its own copy
// of the height grid and registers, predicts one result word for every
// command word, and checks each returned word field by field. It runs
// directed default-grid and register-extreme cases, then random phases on
// mostly small grids with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_terrain_height_sculpt_and_sample;
	import thss_pkg::*;

	localparam int GRID_DEPTH  = 65536;
	localparam int CYCLE_LIMIT = 4000000;
	localparam logic [31:0] ONE = 32'h0001_0000;

	logic         clk;
	logic         arst_n;
	logic         item_valid;
	logic         item_stall;
	thss_item_t   item;
	logic         result_valid;
	logic         result_stall;
	thss_result_t result;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;

	terrain_height_sculpt_and_sample dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow height grid and registers
	logic signed [31:0] shadow_heights [0:GRID_DEPTH-1];
	int unsigned spacing_q, radius_q, strength_q, cols_q, rows_q;

	thss_result_t expected_words[$];
	int  error_count;
	int  cycle_count;
	int  words_sent, queries_sent, edits_sent, writes_sent, words_checked;
	bit  quiet;

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	// result word checker
	always @(posedge clk) begin
		thss_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				if (result.result_height !== want.result_height)
					report_mismatch("result_height", result.result_height, want.result_height);
				if (result.vertices_changed !== want.vertices_changed)
					report_mismatch("vertices_changed", result.vertices_changed,
						want.vertices_changed);
				if (result.cell_col !== want.cell_col)
					report_mismatch("cell_col", result.cell_col, want.cell_col);
				if (result.cell_row !== want.cell_row)
					report_mismatch("cell_row", result.cell_row, want.cell_row);
				if (result.upper_triangle !== want.upper_triangle)
					report_mismatch("upper_triangle", result.upper_triangle,
						want.upper_triangle);
			end
		end
	end

	// receiver stall bursts
	initial begin
		int left;
		left = 0;
		result_stall = 0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				result_stall = 0;
			end else begin
				if (left == 0) begin
					if (result_stall || $urandom_range(0, 1)) begin
						result_stall = 0;
						left = $urandom_range(1, 12);
					end else begin
						result_stall = 1;
						left = $urandom_range(1, 7);
					end
				end
				left--;
			end
		end
	end

	function automatic longint unsigned root64(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint grid_cols();
		return clip(cols_q, 2, 256);
	endfunction

	function automatic longint grid_rows();
		return clip(rows_q, 2, 256);
	endfunction

	function automatic longint step_size();
		return spacing_q != 0 ? longint'(spacing_q) : 1;
	endfunction

	// height on the triangle plane under the point
	task automatic sample_height(input longint px, input longint pz, inout thss_result_t r);
		longint cols, rows, s, x, z, col, row, fx, fz, hll, hlr, hul, hur, num, h;
		bit upper;
		cols = grid_cols();
		rows = grid_rows();
		s = step_size();
		x = clip(px, 0, s * (cols - 1));
		z = clip(pz, 0, s * (rows - 1));
		col = clip(x / s, 0, cols - 2);
		row = clip(z / s, 0, rows - 2);
		fx = x - col * s;
		fz = z - row * s;
		hll = shadow_heights[row * cols + col];
		hlr = shadow_heights[row * cols + col + 1];
		hul = shadow_heights[(row + 1) * cols + col];
		hur = shadow_heights[(row + 1) * cols + col + 1];
		upper = fz > fx;
		if (upper)
			num = (s - fz) * hll + (fz - fx) * hul + fx * hur;
		else
			num = (s - fx) * hll + (fx - fz) * hlr + fz * hur;
		num = num + s / 2;
		h = num / s;
		if ((num % s) != 0 && num < 0) h--;
		h = clip(h, -64'sd2147483648, 64'sd2147483647);
		r.result_height = h[31:0];
		r.cell_col = col[7:0];
		r.cell_row = row[7:0];
		r.upper_triangle = upper;
	endtask

	// brush raise or lower, returns number of vertices inside
	function automatic longint sculpt(input longint px, input longint pz, input bit dig);
		longint cols, rows, s, rad, dx, dz, nh, count;
		longint unsigned d2, dist_v, delta;
		int idx;
		cols = grid_cols();
		rows = grid_rows();
		s = step_size();
		rad = radius_q != 0 ? longint'(radius_q) : 1;
		count = 0;
		for (longint row = 0; row < rows; row++) begin
			dz = row * s - pz;
			if (dz > rad || dz < -rad) continue;
			for (longint col = 0; col < cols; col++) begin
				dx = col * s - px;
				if (dx > rad || dx < -rad) continue;
				d2 = dx * dx + dz * dz;
				if (d2 > rad * rad) continue;
				count++;
				dist_v = root64(d2);
				if (dist_v > rad) dist_v = rad;
				delta = (longint'(strength_q) * (rad - dist_v) + 25 * rad) / (50 * rad);
				idx = row * cols + col;
				nh = longint'(shadow_heights[idx]) + (dig ? -longint'(delta) : longint'(delta));
				nh = clip(nh, -64'sd2147483648, 64'sd2147483647);
				shadow_heights[idx] = nh[31:0];
			end
		end
		return count;
	endfunction

	task automatic predict_word(input thss_item_t w);
		thss_result_t r;
		longint n;
		r = '0;
		case (w.kind)
			KIND_QUERY: begin
				sample_height(longint'($signed(w.pos_x)), longint'($signed(w.pos_z)), r);
				queries_sent++;
			end
			KIND_RAISE, KIND_LOWER: begin
				n = sculpt(longint'($signed(w.pos_x)), longint'($signed(w.pos_z)),
					w.kind == KIND_LOWER);
				r.vertices_changed = n[16:0];
				edits_sent++;
			end
			KIND_WRITE: begin
				if (w.vertex_index < grid_cols() * grid_rows())
					shadow_heights[w.vertex_index] = w.height_value;
				writes_sent++;
			end
			KIND_CLEAR: begin
				foreach (shadow_heights[i]) shadow_heights[i] = '0;
			end
			default: ;
		endcase
		expected_words.push_back(r);
	endtask

	// send one command word, possibly after an idle burst
	task automatic send_word(input thss_item_t w);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
		if (gap > 0) begin
			item_valid = 0;
			repeat (gap) @(negedge clk);
		end
		item_valid = 1;
		item = w;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predict_word(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [2:0] k, input logic [31:0] x, input logic [31:0] z,
			input logic [15:0] vi, input logic [31:0] hv);
		thss_item_t w;
		w.kind = k;
		w.pos_x = x;
		w.pos_z = z;
		w.vertex_index = vi;
		w.height_value = hv;
		send_word(w);
	endtask

	// wait until every expected word is back and the block is idle
	task automatic drain();
		item_valid = 0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_SPACING:  spacing_q = value & 32'h7FFF_FFFF;
			CFG_RADIUS:   radius_q = value & 32'h7FFF_FFFF;
			CFG_STRENGTH: strength_q = value & 32'h7FFF_FFFF;
			CFG_COLS:     cols_q = value & 32'h1FF;
			CFG_ROWS:     rows_q = value & 32'h1FF;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// default 256x256 grid: writes, both triangles, clamping, edits, unknown kinds
	task automatic test_default_grid();
		send_fields(KIND_WRITE, 0, 0, 16'd0, 32'h7FFF_FFFF);
		send_fields(KIND_WRITE, 0, 0, 16'd1, 32'h8000_0000);
		send_fields(KIND_WRITE, 0, 0, 16'd256, 32'h0003_0000);
		send_fields(KIND_WRITE, 0, 0, 16'd257, 32'hFFFE_8000);
		send_fields(KIND_QUERY, 32'h0000_8000, 32'h0000_4000, 16'hFFFF, 32'hFFFF_FFFF);
		send_fields(KIND_QUERY, 32'h0000_4000, 32'h0000_C000, 0, 0);
		send_fields(KIND_QUERY, 32'h8000_0000, 32'h8000_0000, 0, 0);
		send_fields(KIND_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
		send_fields(KIND_QUERY, 32'h7FFF_FFFF, 32'h0000_0000, 0, 0);
		send_fields(KIND_RAISE, 0, 0, 0, 0);
		send_fields(KIND_LOWER, 32'h0003_8000, 32'h0002_4000, 0, 0);
		send_fields(3'd5, $urandom, $urandom, 16'($urandom), $urandom);
		send_fields(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_fields(KIND_WRITE, 0, 0, 16'd65535, 32'hFFFF_FFFF);
		drain();
	endtask

	// register extremes: tiny grid, out-of-range writes, saturation, clamped sizes, clear
	task automatic test_register_extremes();
		write_reg(CFG_COLS, 3);
		write_reg(CFG_ROWS, 2);
		send_fields(KIND_WRITE, 0, 0, 16'd5, 32'h0001_0000);
		send_fields(KIND_WRITE, 0, 0, 16'd6, 32'h1234_5678);
		send_fields(KIND_QUERY, 32'h0001_8000, 32'h0000_8000, 0, 0);
		drain();
		write_reg(CFG_RADIUS, 32'h7FFF_FFFF);
		write_reg(CFG_STRENGTH, 32'hFFFF_FFFF);
		write_reg(CFG_SPACING, 32'h7FFF_FFFF);
		send_fields(KIND_RAISE, 0, 0, 0, 0);
		drain();
		write_reg(CFG_SPACING, 0);
		send_fields(KIND_QUERY, 1, 0, 0, 0);
		send_fields(KIND_RAISE, 1, 1, 0, 0);
		send_fields(KIND_LOWER, 0, 0, 0, 0);
		drain();
		write_reg(CFG_COLS, 0);
		write_reg(CFG_ROWS, 1);
		write_reg(3'd6, 32'hFFFF_FFFF);
		send_fields(KIND_QUERY, 32'h0000_0001, 32'h0000_0000, 0, 0);
		drain();
		write_reg(CFG_COLS, 300);
		write_reg(CFG_ROWS, 511);
		write_reg(CFG_SPACING, ONE);
		write_reg(CFG_RADIUS, 2 * ONE);
		send_fields(KIND_RAISE, 32'h00FE_0000, 32'h00FE_0000, 0, 0);
		send_fields(KIND_CLEAR, $urandom, $urandom, 16'($urandom), $urandom);
		send_fields(KIND_QUERY, 32'h00FE_8000, 32'h00FE_8000, 0, 0);
		drain();
	endtask

	function automatic logic [31:0] random_coord(input longint span);
		longint v;
		if ($urandom_range(0, 9) == 0) return $urandom;
		v = longint'($urandom_range(0, 1000)) * (span + 2 * step_size()) / 1000 - step_size();
		return v[31:0];
	endfunction

	// random phases on mostly small grids
	task automatic test_random_phases();
		thss_item_t w;
		int pick;
		longint s;
		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 3) quiet = 1;
			case ($urandom_range(0, 2))
				0: write_reg(CFG_SPACING, ONE);
				1: write_reg(CFG_SPACING, $urandom_range(1, 16));
				default: write_reg(CFG_SPACING, $urandom_range(256, 32'h4_0000));
			endcase
			if (phase == 1) begin
				write_reg(CFG_COLS, 256);
				write_reg(CFG_ROWS, $urandom_range(2, 5));
			end else begin
				write_reg(CFG_COLS, $urandom_range(2, 16));
				write_reg(CFG_ROWS, $urandom_range(2, 16));
			end
			s = step_size();
			write_reg(CFG_RADIUS, $urandom_range(32'(s / 2 + 1), 32'(3 * s)));
			write_reg(CFG_STRENGTH, phase == 2 ? 0 : $urandom);
			for (int n = 0; n < 25; n++) begin
				pick = $urandom_range(0, 99);
				w.kind = pick < 40 ? KIND_QUERY : pick < 60 ? KIND_RAISE :
					pick < 80 ? KIND_LOWER : pick < 96 ? KIND_WRITE :
					pick < 97 ? KIND_CLEAR : 3'($urandom_range(5, 7));
				w.pos_x = random_coord(s * (grid_cols() - 1));
				w.pos_z = random_coord(s * (grid_rows() - 1));
				w.vertex_index = $urandom_range(0, 4) == 0 ? 16'($urandom) :
					16'($urandom_range(0, 32'(grid_cols() * grid_rows() + 1)));
				w.height_value = $urandom;
				send_word(w);
			end
			drain();
		end
	endtask

	initial begin
		arst_n = 0;
		item_valid = 0;
		item = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 0;
		error_count = 0;
		cycle_count = 0;
		words_sent = 0;
		queries_sent = 0;
		edits_sent = 0;
		writes_sent = 0;
		words_checked = 0;
		foreach (shadow_heights[i]) shadow_heights[i] = '0;
		spacing_q = 65536;
		radius_q = 327680;
		strength_q = 65536;
		cols_q = 256;
		rows_q = 256;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// clearing pass after reset
		@(posedge clk);
		while (item_stall) @(posedge clk);
		@(negedge clk);

		test_default_grid();
		test_register_extremes();
		test_random_phases();

		quiet = 1;
		drain();
		repeat (200) @(posedge clk);
		$display("sent %0d words (%0d queries, %0d edits, %0d writes), checked %0d results",
			words_sent, queries_sent, edits_sent, writes_sent, words_checked);
		$display("mismatches: %0d", error_count);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: files.f
rtl/core/thss_pkg.sv
rtl/core/thss_store.sv
rtl/core/thss_div.sv
rtl/core/thss_sqrt.sv
rtl/core/terrain_height_sculpt_and_sample.sv
sim/tb_terrain_height_sculpt_and_sample.sv
